### hdl/imu_dfr_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// imu_dfr_pkg
// Shared types and constants of the inertial link deframer: the result record
// that travels from the parser to the output stage, and the result kinds.
// ----------------------------------------------------------------------------
package imu_dfr_pkg;

  // result kinds
  localparam logic RESULT_COMPONENT = 1'b0;
  localparam logic RESULT_FRAME_END = 1'b1;

  // depth of the queue between the parser and the output stage
  localparam int QUEUE_DEPTH = 4;
  localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);

  // fixed part of one result record; the raw value travels beside it
  typedef struct packed {
    logic        kind;
    logic [7:0]  field_id;
    logic [1:0]  comp_index;
    logic [2:0]  nbytes_m1;     // bytes received for the value, minus one
    logic [15:0] frame_number;
    logic        checksum_ok;
  } result_rec_t;

endpackage
`default_nettype wire

### hdl/imu_frame_deframer_core.sv
// The edge that accepts the byte finishing a result writes it into the queue;
// the output register loads it from the queue when empty or popped.
// Throughput: one byte per cycle while full is low; full rises only when the
// four-entry result queue is full and the consumer has stopped popping.
// Reset (rst, synchronous): parser back to header hunt, queue and output
// register emptied.
`default_nettype none
// ----------------------------------------------------------------------------
// imu_frame_deframer_core
// Deframer for a byte-serial inertial link: parser front end, result queue
// and sign-extending output stage.
// ----------------------------------------------------------------------------
module imu_frame_deframer_core
  import imu_dfr_pkg::*;
#(
  parameter int VALUE_BITS = 64
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               push,
  output logic                    full,
  input  wire logic [7:0]         rx_byte,
  output logic                    empty,
  input  wire logic               pop,
  output logic                    result_kind,
  output logic [7:0]              field_id,
  output logic [1:0]              component_index,
  output logic signed [63:0]      component_value,
  output logic [15:0]             frame_number,
  output logic                    checksum_ok
);

  logic                  take;
  logic                  emit;
  result_rec_t           front_rec;
  logic [VALUE_BITS-1:0] front_value;
  logic                  q_rd;
  logic                  q_nonempty;
  result_rec_t           q_rec;
  logic [VALUE_BITS-1:0] q_value;

  // byte transfer
  assign take = push && !full;

  imu_dfr_front #(.VALUE_BITS(VALUE_BITS)) u_front (
    .clk       (clk),
    .rst       (rst),
    .take      (take),
    .rx_byte   (rx_byte),
    .emit      (emit),
    .rec       (front_rec),
    .rec_value (front_value)
  );

  imu_dfr_queue #(.VALUE_BITS(VALUE_BITS)) u_queue (
    .clk      (clk),
    .rst      (rst),
    .wr_en    (emit),
    .wr_rec   (front_rec),
    .wr_value (front_value),
    .rd_en    (q_rd),
    .rd_rec   (q_rec),
    .rd_value (q_value),
    .full     (full),
    .nonempty (q_nonempty)
  );

  imu_dfr_back #(.VALUE_BITS(VALUE_BITS)) u_back (
    .clk             (clk),
    .rst             (rst),
    .q_nonempty      (q_nonempty),
    .q_rec           (q_rec),
    .q_value         (q_value),
    .q_rd            (q_rd),
    .pop             (pop),
    .empty           (empty),
    .result_kind     (result_kind),
    .field_id        (field_id),
    .component_index (component_index),
    .component_value (component_value),
    .frame_number    (frame_number),
    .checksum_ok     (checksum_ok)
  );

endmodule
`default_nettype wire

### hdl/imu_dfr_front.sv
`default_nettype none
// ----------------------------------------------------------------------------
// imu_dfr_front
// Byte parser: header hunt, frame number, length, running checksum pair and
// field walk. Builds a raw result record per known-field component and frame.
// ----------------------------------------------------------------------------
module imu_dfr_front
  import imu_dfr_pkg::*;
#(
  parameter int VALUE_BITS = 64
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  take,
  input  wire logic [7:0]            rx_byte,
  output logic                       emit,
  output result_rec_t                rec,
  output logic [VALUE_BITS-1:0]      rec_value
);

  localparam logic [7:0] HDR_FIRST  = 8'h59;
  localparam logic [7:0] HDR_SECOND = 8'h53;

  // decoded field identifiers
  localparam logic [7:0] ID_TEMP     = 8'h01;
  localparam logic [7:0] ID_ACCEL    = 8'h10;
  localparam logic [7:0] ID_GYRO     = 8'h20;
  localparam logic [7:0] ID_MAG_NORM = 8'h30;
  localparam logic [7:0] ID_MAG_RAW  = 8'h31;
  localparam logic [7:0] ID_EULER    = 8'h40;
  localparam logic [7:0] ID_QUAT     = 8'h41;
  localparam logic [7:0] ID_GNSS     = 8'h68;
  localparam logic [7:0] ID_TIME     = 8'h70;

  typedef enum logic [3:0] {
    PH_HUNT1, PH_HUNT2, PH_FN0, PH_FN1, PH_LEN,
    PH_FID, PH_FLEN, PH_FDATA, PH_CK1, PH_CK2
  } phase_t;

  phase_t                phase;
  logic [15:0]           frame_num;
  logic [7:0]            payload_len;
  logic [7:0]            payload_count;
  logic [7:0]            sum_first;
  logic [7:0]            sum_second;
  logic [7:0]            current_id;
  logic [7:0]            field_len;
  logic [7:0]            field_count;
  logic [1:0]            comp_index;
  logic [VALUE_BITS-1:0] value_acc;
  logic [7:0]            first_check_byte;

  logic [7:0]            sum_first_next;
  logic [7:0]            sum_second_next;
  logic [7:0]            payload_count_next;
  logic [7:0]            field_count_next;
  logic                  long_value;
  logic [2:0]            pos;
  logic                  comp_last;
  logic                  field_end;
  logic                  comp_done;
  logic [63:0]           byte_shifted;
  logic [VALUE_BITS-1:0] value_acc_next;
  logic                  id_known;

  function automatic logic known_id(input logic [7:0] id);
    case (id)
      ID_TEMP, ID_ACCEL, ID_GYRO, ID_MAG_NORM, ID_MAG_RAW,
      ID_EULER, ID_QUAT, ID_GNSS, ID_TIME: known_id = 1'b1;
      default: known_id = 1'b0;
    endcase
  endfunction

  // running sums, counters and data byte placement
  always_comb begin
    sum_first_next     = sum_first + rx_byte;
    sum_second_next    = sum_second + sum_first_next;
    payload_count_next = payload_count + 8'd1;
    field_count_next   = field_count + 8'd1;
    long_value         = (current_id == ID_GNSS) && (field_count < 8'd16);
    pos                = long_value ? field_count[2:0] : {1'b0, field_count[1:0]};
    comp_last          = long_value ? (pos == 3'd7) : (pos == 3'd3);
    field_end          = (field_count_next == field_len) ||
                         (payload_count_next == payload_len);
    comp_done          = comp_last || field_end;
    byte_shifted       = {56'd0, rx_byte} << {pos, 3'b000};
    value_acc_next     = value_acc | byte_shifted[VALUE_BITS-1:0];
    id_known           = known_id(current_id);
  end

  // result record for this byte
  always_comb begin
    emit               = 1'b0;
    rec.kind           = RESULT_COMPONENT;
    rec.field_id       = current_id;
    rec.comp_index     = comp_index;
    rec.nbytes_m1      = pos;
    rec.frame_number   = frame_num;
    rec.checksum_ok    = 1'b0;
    rec_value          = value_acc_next;
    case (phase)
      PH_FDATA: begin
        emit = take && comp_done && id_known;
      end
      PH_CK2: begin
        emit            = take;
        rec.kind        = RESULT_FRAME_END;
        rec.field_id    = 8'd0;
        rec.comp_index  = 2'd0;
        rec.nbytes_m1   = 3'd0;
        rec.checksum_ok = (first_check_byte == sum_first) && (rx_byte == sum_second);
        rec_value       = '0;
      end
      default: begin
        emit = 1'b0;
      end
    endcase
  end

  // parse state
  always_ff @(posedge clk) begin
    if (rst) begin
      phase            <= PH_HUNT1;
      frame_num        <= '0;
      payload_len      <= '0;
      payload_count    <= '0;
      sum_first        <= '0;
      sum_second       <= '0;
      current_id       <= '0;
      field_len        <= '0;
      field_count      <= '0;
      comp_index       <= '0;
      value_acc        <= '0;
      first_check_byte <= '0;
    end else if (take) begin
      case (phase)
        PH_HUNT2: begin
          if (rx_byte == HDR_SECOND) begin
            phase <= PH_FN0;
          end else if (rx_byte != HDR_FIRST) begin
            phase <= PH_HUNT1;
          end
        end
        PH_FN0: begin
          sum_first  <= rx_byte;
          sum_second <= rx_byte;
          frame_num  <= {8'd0, rx_byte};
          phase      <= PH_FN1;
        end
        PH_FN1: begin
          sum_first       <= sum_first_next;
          sum_second      <= sum_second_next;
          frame_num[15:8] <= rx_byte;
          phase           <= PH_LEN;
        end
        PH_LEN: begin
          sum_first     <= sum_first_next;
          sum_second    <= sum_second_next;
          payload_len   <= rx_byte;
          payload_count <= '0;
          phase         <= (rx_byte == 8'd0) ? PH_CK1 : PH_FID;
        end
        PH_FID: begin
          sum_first     <= sum_first_next;
          sum_second    <= sum_second_next;
          current_id    <= rx_byte;
          payload_count <= payload_count_next;
          phase         <= (payload_count_next == payload_len) ? PH_CK1 : PH_FLEN;
        end
        PH_FLEN: begin
          sum_first     <= sum_first_next;
          sum_second    <= sum_second_next;
          field_len     <= rx_byte;
          field_count   <= '0;
          comp_index    <= '0;
          value_acc     <= '0;
          payload_count <= payload_count_next;
          if (payload_count_next == payload_len) begin
            phase <= PH_CK1;
          end else if (rx_byte == 8'd0) begin
            phase <= PH_FID;
          end else begin
            phase <= PH_FDATA;
          end
        end
        PH_FDATA: begin
          sum_first     <= sum_first_next;
          sum_second    <= sum_second_next;
          field_count   <= field_count_next;
          payload_count <= payload_count_next;
          if (comp_done) begin
            comp_index <= comp_index + 2'd1;
            value_acc  <= '0;
          end else begin
            value_acc <= value_acc_next;
          end
          if (field_end) begin
            phase <= (payload_count_next == payload_len) ? PH_CK1 : PH_FID;
          end
        end
        PH_CK1: begin
          first_check_byte <= rx_byte;
          phase            <= PH_CK2;
        end
        PH_CK2: begin
          phase <= PH_HUNT1;
        end
        default: begin
          phase <= (rx_byte == HDR_FIRST) ? PH_HUNT2 : PH_HUNT1;
        end
      endcase
    end
  end

endmodule
`default_nettype wire

### hdl/imu_dfr_queue.sv
`default_nettype none
// ----------------------------------------------------------------------------
// imu_dfr_queue
// Short first-word-fall-through queue of raw result records between the
// parser and the output stage.
// ----------------------------------------------------------------------------
module imu_dfr_queue
  import imu_dfr_pkg::*;
#(
  parameter int VALUE_BITS = 64
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  wr_en,
  input  wire result_rec_t           wr_rec,
  input  wire logic [VALUE_BITS-1:0] wr_value,
  input  wire logic                  rd_en,
  output result_rec_t                rd_rec,
  output logic [VALUE_BITS-1:0]      rd_value,
  output logic                       full,
  output logic                       nonempty
);

  result_rec_t           rec_mem   [QUEUE_DEPTH];
  logic [VALUE_BITS-1:0] value_mem [QUEUE_DEPTH];
  logic [QUEUE_PTR_W-1:0] wr_ptr;
  logic [QUEUE_PTR_W-1:0] rd_ptr;
  logic [QUEUE_PTR_W:0]   count;

  assign full     = (count == (QUEUE_PTR_W + 1)'(QUEUE_DEPTH));
  assign nonempty = (count != '0);
  assign rd_rec   = rec_mem[rd_ptr];
  assign rd_value = value_mem[rd_ptr];

  // storage
  always_ff @(posedge clk) begin
    if (wr_en) begin
      rec_mem[wr_ptr]   <= wr_rec;
      value_mem[wr_ptr] <= wr_value;
    end
  end

  // pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (wr_en) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (rd_en) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (wr_en && !rd_en) begin
        count <= count + 1'b1;
      end else if (rd_en && !wr_en) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule
`default_nettype wire

### hdl/imu_dfr_back.sv
`default_nettype none
// ----------------------------------------------------------------------------
// imu_dfr_back
// Output stage: sign-extends each raw value from its received byte count
// (limited to the value width) and holds the result for the consumer.
// ----------------------------------------------------------------------------
module imu_dfr_back
  import imu_dfr_pkg::*;
#(
  parameter int VALUE_BITS = 64
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  q_nonempty,
  input  wire result_rec_t           q_rec,
  input  wire logic [VALUE_BITS-1:0] q_value,
  output logic                       q_rd,
  input  wire logic                  pop,
  output logic                       empty,
  output logic                       result_kind,
  output logic [7:0]                 field_id,
  output logic [1:0]                 component_index,
  output logic signed [63:0]         component_value,
  output logic [15:0]                frame_number,
  output logic                       checksum_ok
);

  localparam int IDX_W = $clog2(VALUE_BITS);

  logic        out_valid;
  logic [6:0]  byte_bits;
  logic [6:0]  sign_pos;
  logic        sign_bit;
  logic [63:0] raw_wide;
  logic [63:0] value_ext;

  assign empty = !out_valid;
  assign q_rd  = q_nonempty && (!out_valid || pop);

  // sign extension from min(8 * bytes, VALUE_BITS) bits
  always_comb begin
    byte_bits = {1'b0, q_rec.nbytes_m1, 3'b111};
    sign_pos  = (byte_bits < 7'(VALUE_BITS)) ? byte_bits : 7'(VALUE_BITS - 1);
    sign_bit  = q_value[sign_pos[IDX_W-1:0]];
    raw_wide  = 64'(q_value);
    for (int i = 0; i < 64; i++) begin
      value_ext[i] = (7'(i) <= sign_pos) ? raw_wide[i] : sign_bit;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (!out_valid || pop) begin
      out_valid <= q_nonempty;
    end
  end

  always_ff @(posedge clk) begin
    if (q_rd) begin
      result_kind     <= q_rec.kind;
      field_id        <= q_rec.field_id;
      component_index <= q_rec.comp_index;
      component_value <= value_ext;
      frame_number    <= q_rec.frame_number;
      checksum_ok     <= q_rec.checksum_ok;
    end
  end

endmodule
`default_nettype wire

### bench/testbench.sv
`default_nettype none
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for imu_frame_deframer_core. Byte streams of framed
// inertial data (well-formed frames with random fields, corrupt check bytes,
// cut frames and line noise) go in through the push side. A byte-level
// predictor of the parser tracks every accepted byte and queues the values
// and frame-end results it expects. The pop side compares them in order.
// ----------------------------------------------------------------------------
module testbench;
  import imu_dfr_pkg::*;

  localparam int VALUE_BITS      = 64;
  localparam int CLK_PERIOD      = 12;
  localparam int RESET_CYCLES    = 4;
  localparam int CYCLE_LIMIT     = 400000;
  localparam int RANDOM_BYTES    = 420;
  localparam int HOLD_OFF_CYCLES = 80;
  localparam int SETTLE_CYCLES   = 10;

  // header and field identifiers
  localparam logic [7:0] SYNC_FIRST   = 8'h59;
  localparam logic [7:0] SYNC_SECOND  = 8'h53;
  localparam logic [7:0] ID_TEMP      = 8'h01;
  localparam logic [7:0] ID_ACCEL     = 8'h10;
  localparam logic [7:0] ID_ANG_RATE  = 8'h20;
  localparam logic [7:0] ID_MAG_NORM  = 8'h30;
  localparam logic [7:0] ID_MAG_RAW   = 8'h31;
  localparam logic [7:0] ID_EULER     = 8'h40;
  localparam logic [7:0] ID_QUAT      = 8'h41;
  localparam logic [7:0] ID_POSITION  = 8'h68;
  localparam logic [7:0] ID_TIMESTAMP = 8'h70;
  localparam logic [7:0] ID_UNKNOWN   = 8'h99;

  typedef enum logic [3:0] {
    SEEK_SYNC1, SEEK_SYNC2, GET_NUM_LO, GET_NUM_HI, GET_LEN,
    GET_FIELD_ID, GET_FIELD_LEN, GET_FIELD_DATA, GET_CHECK1, GET_CHECK2
  } parse_phase_t;

  typedef struct {
    logic               kind;
    logic [7:0]         field_id;
    logic [1:0]         comp;
    logic signed [63:0] value;
    logic [15:0]        frame_no;
    logic               sum_ok;
  } deframed_result_t;

  typedef logic [7:0] byte_q_t[$];

  logic               clk;
  logic               rst = 1'b1;
  logic               push = 1'b0;
  logic [7:0]         rx_byte = 8'h00;
  logic               pop = 1'b0;
  logic               full;
  logic               empty;
  logic               result_kind;
  logic [7:0]         field_id;
  logic [1:0]         component_index;
  logic signed [63:0] component_value;
  logic [15:0]        frame_number;
  logic               checksum_ok;

  imu_frame_deframer_core #(
    .VALUE_BITS(VALUE_BITS)
  ) dut (
    .clk(clk),
    .rst(rst),
    .push(push),
    .full(full),
    .rx_byte(rx_byte),
    .empty(empty),
    .pop(pop),
    .result_kind(result_kind),
    .field_id(field_id),
    .component_index(component_index),
    .component_value(component_value),
    .frame_number(frame_number),
    .checksum_ok(checksum_ok)
  );

  // predictor state
  parse_phase_t phase = SEEK_SYNC1;
  logic [15:0]  frame_no = '0;
  logic [7:0]   pay_len = '0;
  logic [7:0]   pay_cnt = '0;
  logic [7:0]   sum_a = '0;
  logic [7:0]   sum_b = '0;
  logic [7:0]   cur_id = '0;
  logic [7:0]   fld_len = '0;
  logic [7:0]   fld_cnt = '0;
  logic [1:0]   comp_idx = '0;
  logic [63:0]  value_acc = '0;
  logic [7:0]   check_a = '0;

  deframed_result_t pending_results[$];
  byte_q_t          stream;

  bit steady_send = 1'b0;
  bit steady_pop = 1'b0;
  int hold_off_request = 0;
  int fail_count = 0;
  int cycle_count = 0;
  int bytes_sent = 0;
  int values_seen = 0;
  int frames_good = 0;
  int frames_bad = 0;
  int full_cycles = 0;

  // clock
  initial begin
    clk = 1'b0;
    forever #(CLK_PERIOD / 2) clk = ~clk;
  end

  // run limit and input stall count
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (push && full) full_cycles <= full_cycles + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycle_count,
               pending_results.size());
      $display("Regression FAIL");
      $finish;
    end
  end

  function automatic logic signed [63:0] sign_extend(logic [63:0] v, int unsigned nbits);
    logic signed [63:0] t;
    if (nbits == 0 || nbits >= 64) return v;
    t = v << (64 - nbits);
    return t >>> (64 - nbits);
  endfunction

  function automatic bit is_known_id(logic [7:0] id);
    case (id)
      ID_TEMP, ID_ACCEL, ID_ANG_RATE, ID_MAG_NORM, ID_MAG_RAW,
      ID_EULER, ID_QUAT, ID_POSITION, ID_TIMESTAMP: return 1'b1;
      default: return 1'b0;
    endcase
  endfunction

  function automatic void add_to_sums(logic [7:0] b);
    sum_a = sum_a + b;
    sum_b = sum_b + sum_a;
  endfunction

  // advance the parser by one accepted byte and queue what it should emit
  function automatic void deframe_byte(logic [7:0] b);
    int unsigned      pos;
    int unsigned      size;
    bit               field_end;
    deframed_result_t r;
    case (phase)
      SEEK_SYNC2: begin
        if (b == SYNC_SECOND) phase = GET_NUM_LO;
        else if (b != SYNC_FIRST) phase = SEEK_SYNC1;
      end
      GET_NUM_LO: begin
        sum_a = '0;
        sum_b = '0;
        add_to_sums(b);
        frame_no = {8'h00, b};
        phase = GET_NUM_HI;
      end
      GET_NUM_HI: begin
        add_to_sums(b);
        frame_no[15:8] = b;
        phase = GET_LEN;
      end
      GET_LEN: begin
        add_to_sums(b);
        pay_len = b;
        pay_cnt = '0;
        phase = (b == 8'd0) ? GET_CHECK1 : GET_FIELD_ID;
      end
      GET_FIELD_ID: begin
        add_to_sums(b);
        cur_id = b;
        pay_cnt = pay_cnt + 8'd1;
        phase = (pay_cnt == pay_len) ? GET_CHECK1 : GET_FIELD_LEN;
      end
      GET_FIELD_LEN: begin
        add_to_sums(b);
        fld_len = b;
        fld_cnt = '0;
        comp_idx = '0;
        value_acc = '0;
        pay_cnt = pay_cnt + 8'd1;
        if (pay_cnt == pay_len) phase = GET_CHECK1;
        else if (b == 8'd0) phase = GET_FIELD_ID;
        else phase = GET_FIELD_DATA;
      end
      GET_FIELD_DATA: begin
        add_to_sums(b);
        // latitude and longitude of the position field are eight bytes wide
        if (cur_id == ID_POSITION && fld_cnt < 8'd16) begin
          pos = 32'(fld_cnt[2:0]);
          size = 8;
        end else begin
          pos = 32'(fld_cnt[1:0]);
          size = 4;
        end
        value_acc = value_acc | ({56'd0, b} << (8 * pos));
        fld_cnt = fld_cnt + 8'd1;
        pay_cnt = pay_cnt + 8'd1;
        field_end = (fld_cnt == fld_len) || (pay_cnt == pay_len);
        if (pos + 1 == size || field_end) begin
          if (is_known_id(cur_id)) begin
            r.kind = RESULT_COMPONENT;
            r.field_id = cur_id;
            r.comp = comp_idx;
            r.value = sign_extend(sign_extend(value_acc, 8 * (pos + 1)), VALUE_BITS);
            r.frame_no = frame_no;
            r.sum_ok = 1'b0;
            pending_results = {pending_results, r};
          end
          comp_idx = comp_idx + 2'd1;
          value_acc = '0;
        end
        if (field_end) phase = (pay_cnt == pay_len) ? GET_CHECK1 : GET_FIELD_ID;
      end
      GET_CHECK1: begin
        check_a = b;
        phase = GET_CHECK2;
      end
      GET_CHECK2: begin
        r.kind = RESULT_FRAME_END;
        r.field_id = '0;
        r.comp = '0;
        r.value = '0;
        r.frame_no = frame_no;
        r.sum_ok = (check_a == sum_a) && (b == sum_b);
        pending_results = {pending_results, r};
        phase = SEEK_SYNC1;
      end
      default: phase = (b == SYNC_FIRST) ? SEEK_SYNC2 : SEEK_SYNC1;
    endcase
  endfunction

  // queue a framed payload, optionally with one check byte damaged
  function automatic void append_frame(logic [15:0] num, byte_q_t body, bit bad_sum);
    logic [7:0] len_byte;
    logic [7:0] ck_a;
    logic [7:0] ck_b;
    byte_q_t    covered;
    len_byte = 8'(body.size());
    covered = body;
    covered.push_front(len_byte);
    covered.push_front(num[15:8]);
    covered.push_front(num[7:0]);
    ck_a = '0;
    ck_b = '0;
    stream = {stream, SYNC_FIRST};
    stream = {stream, SYNC_SECOND};
    foreach (covered[i]) begin
      ck_a = ck_a + covered[i];
      ck_b = ck_b + ck_a;
      stream = {stream, covered[i]};
    end
    if (bad_sum) begin
      if ($urandom_range(0, 1) == 0) ck_a = ck_a ^ 8'($urandom_range(1, 255));
      else ck_b = ck_b ^ 8'($urandom_range(1, 255));
    end
    stream = {stream, ck_a};
    stream = {stream, ck_b};
  endfunction

  // frame with a random chain of fields, sometimes cut short or corrupted
  function automatic void append_random_frame(bit allow_faults);
    byte_q_t    body;
    logic [7:0] id;
    logic [7:0] flen;
    logic [7:0] data;
    int         target;
    int         cut;
    target = $urandom_range(0, 48);
    while (body.size() < target) begin
      case ($urandom_range(0, 10))
        0: id = ID_TEMP;
        1: id = ID_ACCEL;
        2: id = ID_ANG_RATE;
        3: id = ID_MAG_NORM;
        4: id = ID_MAG_RAW;
        5: id = ID_EULER;
        6: id = ID_QUAT;
        7: id = ID_POSITION;
        8: id = ID_TIMESTAMP;
        default: id = 8'($urandom_range(0, 255));
      endcase
      if ($urandom_range(0, 3) == 0) flen = 8'($urandom_range(0, 30));
      else if (id == ID_POSITION) flen = 8'd24;
      else flen = ($urandom_range(0, 1) == 0) ? 8'd12 : 8'd16;
      body = {body, id};
      body = {body, flen};
      repeat (flen) begin
        case ($urandom_range(0, 7))
          0: data = 8'h00;
          1: data = 8'hff;
          2: data = 8'h80;
          3: data = 8'h7f;
          default: data = 8'($urandom_range(0, 255));
        endcase
        body = {body, data};
      end
    end
    // payload length shorter than the fields it holds
    if (allow_faults && $urandom_range(0, 3) == 0) begin
      cut = $urandom_range(0, body.size());
      while (body.size() > cut) void'(body.pop_back());
    end
    append_frame(16'($urandom_range(0, 65535)), body,
                 allow_faults && $urandom_range(0, 5) == 0);
  endfunction

  // one byte transfer on the push side
  task automatic send_byte(input logic [7:0] b);
    int gap;
    gap = steady_send ? 0 : $urandom_range(0, 9);
    if (gap > 0) begin
      push <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    push <= 1'b1;
    rx_byte <= b;
    do @(posedge clk); while (full);
    deframe_byte(b);
    bytes_sent++;
  endtask

  task automatic send_stream();
    foreach (stream[i]) send_byte(stream[i]);
    stream.delete();
  endtask

  // stop sending until every expected result has been popped
  task automatic wait_for_results();
    push <= 1'b0;
    @(posedge clk);
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  function automatic void check_field(string name, logic [63:0] want, logic [63:0] got);
    if (got !== want) begin
      $error("%s: expected %0h, actual %0h", name, want, got);
      fail_count++;
    end
  endfunction

  // pop side: random stalls, an occasional long hold-off, in-order compare
  initial begin : result_checker
    int               stall;
    deframed_result_t want;
    wait (rst == 1'b0);
    @(posedge clk);
    forever begin
      if (hold_off_request > 0) begin
        stall = hold_off_request;
        hold_off_request = 0;
      end else begin
        stall = steady_pop ? 0 : $urandom_range(0, 9);
      end
      if (stall > 0) begin
        pop <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      pop <= 1'b1;
      do @(posedge clk); while (empty);
      if (pending_results.size() == 0) begin
        $error("unexpected result: kind %0d id %0h frame %0h", result_kind, field_id,
               frame_number);
        fail_count++;
      end else begin
        want = pending_results[0];
        pending_results.delete(0);
        check_field("result_kind", 64'(want.kind), 64'(result_kind));
        check_field("field_id", 64'(want.field_id), 64'(field_id));
        check_field("component_index", 64'(want.comp), 64'(component_index));
        check_field("component_value", want.value, component_value);
        check_field("frame_number", 64'(want.frame_no), 64'(frame_number));
        check_field("checksum_ok", 64'(want.sum_ok), 64'(checksum_ok));
        if (want.kind == RESULT_COMPONENT) values_seen++;
        else if (want.sum_ok) frames_good++;
        else frames_bad++;
      end
      if ($urandom_range(0, 24) == 0) steady_pop = !steady_pop;
    end
  end

  // repeated first header byte, wrong second header byte, empty payloads
  task automatic test_header_resync();
    byte_q_t none;
    stream = '{8'h00, SYNC_FIRST, SYNC_FIRST};
    append_frame(16'h0000, none, 1'b0);
    stream = {stream, SYNC_FIRST};
    stream = {stream, 8'h12};
    stream = {stream, SYNC_SECOND};
    append_frame(16'hffff, none, 1'b1);
    send_stream();
    wait_for_results();
  endtask

  // empty field, short component, unknown id, field past payload end
  task automatic test_field_shapes();
    byte_q_t body;
    body = '{ID_TEMP, 8'h00,
             ID_ACCEL, 8'h06, 8'h01, 8'h02, 8'h03, 8'h04, 8'h7f, 8'h80,
             ID_UNKNOWN, 8'h03, 8'haa, 8'hbb, 8'hcc,
             ID_ANG_RATE, 8'h04, 8'hff, 8'hff, 8'hff, 8'hff};
    append_frame(16'h1234, body, 1'b0);
    append_frame(16'h1235, body, 1'b1);
    body = '{ID_MAG_RAW, 8'h10, 8'h00, 8'h00, 8'h80};
    append_frame(16'h00a5, body, 1'b0);
    // id byte, then length byte, as the last payload byte
    body = '{ID_EULER, 8'h01, 8'h80, ID_QUAT};
    append_frame(16'h5a00, body, 1'b0);
    body = '{ID_TIMESTAMP, 8'h05};
    append_frame(16'h0102, body, 1'b0);
    send_stream();
    wait_for_results();
  endtask

  // eight-byte latitude and longitude at both extremes, then four-byte parts
  task automatic test_position_field();
    byte_q_t body;
    body = '{ID_POSITION, 8'd24,
             8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h80,
             8'hff, 8'hff, 8'hff, 8'hff, 8'hff, 8'hff, 8'hff, 8'h7f,
             8'h00, 8'h00, 8'h00, 8'h80, 8'hff, 8'hff, 8'hff, 8'h7f};
    append_frame(16'h8001, body, 1'b0);
    send_stream();
    wait_for_results();
  endtask

  // long pop hold-off while bytes keep coming, so the result queue fills
  task automatic test_full_queue();
    byte_q_t body;
    body = '{ID_ACCEL, 8'd12, 8'h11, 8'h22, 8'h33, 8'h44, 8'h55, 8'h66, 8'h77, 8'h88,
             8'h99, 8'haa, 8'hbb, 8'hcc,
             ID_QUAT, 8'd16, 8'h01, 8'h00, 8'h00, 8'h80, 8'hfe, 8'hff, 8'hff, 8'h7f,
             8'h10, 8'h20, 8'h30, 8'h40, 8'hf0, 8'he0, 8'hd0, 8'hc0};
    steady_send = 1'b1;
    hold_off_request = HOLD_OFF_CYCLES;
    for (int i = 0; i < 6; i++) append_frame(16'(16'h0200 + i), body, 1'b0);
    send_stream();
    steady_send = 1'b0;
    wait_for_results();
  endtask

  // mostly well-formed frames, with noise, cut frames and bad check bytes
  task automatic test_random_stream();
    int sent;
    sent = 0;
    while (sent < RANDOM_BYTES) begin
      steady_send = ($urandom_range(0, 4) == 0);
      case ($urandom_range(0, 9))
        0: begin
          repeat ($urandom_range(1, 12)) begin
            stream = {stream, (($urandom_range(0, 3) == 0) ? SYNC_FIRST :
                               8'($urandom_range(0, 255)))};
          end
        end
        1: begin
          append_random_frame(1'b1);
          repeat ($urandom_range(1, stream.size() - 1)) void'(stream.pop_back());
        end
        default: append_random_frame(1'b1);
      endcase
      sent += stream.size();
      send_stream();
      if ($urandom_range(0, 19) == 0) wait_for_results();
    end
    steady_send = 1'b0;
  endtask

  // main sequence
  initial begin
    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_header_resync();
    test_field_shapes();
    test_position_field();
    test_full_queue();
    test_random_stream();
    wait_for_results();
    repeat (SETTLE_CYCLES) @(posedge clk);
    $display("covered %0d bytes: %0d component values, %0d good and %0d bad frame ends",
             bytes_sent, values_seen, frames_good, frames_bad);
    $display("push side held off by a full queue for %0d cycles", full_cycles);
    if (fail_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
`default_nettype wire
